// ===== hdl/nsfc_pkg.sv =====
package nsfc_pkg;

   // Default sentence buffer capacity in bytes
   localparam int unsigned LineCapacityDefault = 128;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned StatusW = 2;
   localparam int unsigned KindW   = 2;
   localparam int unsigned LengthW = 7;

   // Characters of interest
   localparam logic [ByteW-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [ByteW-1:0] CHAR_STAR   = 8'h2A;
   localparam logic [ByteW-1:0] CHAR_LF     = 8'h0A;
   localparam logic [ByteW-1:0] CHAR_NUL    = 8'h00;

   // Result status codes
   localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
   localparam logic [StatusW-1:0] STATUS_BAD   = 2'd1;
   localparam logic [StatusW-1:0] STATUS_OTHER = 2'd2;

   // Sentence kind codes
   localparam logic [KindW-1:0] KIND_NONE = 2'd0;
   localparam logic [KindW-1:0] KIND_RMC  = 2'd1;
   localparam logic [KindW-1:0] KIND_GGA  = 2'd2;
   localparam logic [KindW-1:0] KIND_VTG  = 2'd3;

   // Checksum field progress
   typedef enum logic [3:0] {
      PH_BEFORE_STAR = 4'b0001,
      PH_HIGH_DIGIT  = 4'b0010,
      PH_LOW_DIGIT   = 4'b0100,
      PH_DIGITS_DONE = 4'b1000
   } phase_type;

   // One finished sentence
   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [KindW-1:0]   kind;
      logic [LengthW-1:0] length;
   } result_type;

   // Character of a sentence name: name 0 RMC, 1 GGA, 2 VTG; position 0..2
   function automatic logic [ByteW-1:0] name_char(input logic [1:0] name,
                                                  input logic [1:0] idx);
      logic [ByteW-1:0] c;
      c = 8'h00;
      case (name)
         2'd0: begin
            case (idx)
               2'd0:    c = 8'h52; // R
               2'd1:    c = 8'h4D; // M
               default: c = 8'h43; // C
            endcase
         end
         2'd1: begin
            case (idx)
               2'd0:    c = 8'h47; // G
               2'd1:    c = 8'h47; // G
               default: c = 8'h41; // A
            endcase
         end
         default: begin
            case (idx)
               2'd0:    c = 8'h56; // V
               2'd1:    c = 8'h54; // T
               default: c = 8'h47; // G
            endcase
         end
      endcase
      return c;
   endfunction

   // Hex digit decode: bit 4 flags a valid digit, bits 3:0 the value
   function automatic logic [4:0] hex_decode(input logic [ByteW-1:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

// ===== hdl/nsfc_in_reg.sv =====
module nsfc_in_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [nsfc_pkg::ByteW-1:0] req_rx_byte,
   input  logic                      take,
   output logic                      word_valid,
   output logic [nsfc_pkg::ByteW-1:0] word_byte
);
   import nsfc_pkg::*;

   logic             valid_ff, valid_in;
   logic [ByteW-1:0] byte_ff, byte_in;
   logic             load;

   // Accept a new word when empty or when the held word moves on
   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign word_valid = valid_ff;
   assign word_byte  = byte_ff;

endmodule

// ===== hdl/nsfc_framer.sv =====
module nsfc_framer #(
   parameter int unsigned LINE_CAPACITY = nsfc_pkg::LineCapacityDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  logic [nsfc_pkg::ByteW-1:0] rx_byte,
   output logic                       emit,
   output nsfc_pkg::result_type       result
);
   import nsfc_pkg::*;

   localparam int unsigned CountW = $clog2(LINE_CAPACITY);
   localparam int unsigned LenW   = (CountW > LengthW) ? CountW : LengthW;

   logic              in_sentence_ff, in_sentence_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [ByteW-1:0]  xor_ff, xor_in;
   phase_type         phase_ff, phase_in;
   logic [3:0]        high_ff, high_in;
   logic              ferr_ff, ferr_in;
   logic [2:0]        match_ff, match_in;

   // Work through one byte against the sentence state
   always_comb begin
      logic [CountW-1:0] pos;
      logic [4:0]        hex;
      logic [LenW-1:0]   len_wide;
      in_sentence_in = in_sentence_ff;
      count_in       = count_ff;
      xor_in         = xor_ff;
      phase_in       = phase_ff;
      high_in        = high_ff;
      ferr_in        = ferr_ff;
      match_in       = match_ff;
      emit           = 1'b0;
      result         = '0;
      pos            = count_ff;
      hex            = hex_decode(rx_byte);
      len_wide       = '0;
      if (fire) begin
         // A dollar always opens a fresh sentence
         if (rx_byte == CHAR_DOLLAR) begin
            in_sentence_in = 1'b1;
            count_in       = '0;
            xor_in         = '0;
            phase_in       = PH_BEFORE_STAR;
            high_in        = '0;
            ferr_in        = 1'b0;
            match_in       = 3'b111;
         end
         if (in_sentence_in) begin
            if (count_in >= CountW'(LINE_CAPACITY - 1)) begin
               // Drop an overlong sentence without a result
               in_sentence_in = 1'b0;
               count_in       = '0;
               xor_in         = '0;
               phase_in       = PH_BEFORE_STAR;
               high_in        = '0;
               ferr_in        = 1'b0;
               match_in       = 3'b111;
            end else begin
               pos      = count_in;
               count_in = count_in + CountW'(1);
               // Match the sentence name
               if (pos >= CountW'(3) && pos <= CountW'(5)) begin
                  for (int k = 0; k < 3; k++) begin
                     if (name_char(2'(k), 2'(pos - CountW'(3))) != rx_byte) begin
                        match_in[k] = 1'b0;
                     end
                  end
               end
               // Checksum body and digits
               if (pos != '0) begin
                  case (phase_in)
                     PH_BEFORE_STAR: begin
                        if (rx_byte == CHAR_STAR) begin
                           phase_in = PH_HIGH_DIGIT;
                        end else begin
                           if (rx_byte == CHAR_NUL) ferr_in = 1'b1;
                           xor_in = xor_in ^ rx_byte;
                        end
                     end
                     PH_HIGH_DIGIT: begin
                        high_in = hex[3:0];
                        if (!hex[4]) ferr_in = 1'b1;
                        phase_in = PH_LOW_DIGIT;
                     end
                     PH_LOW_DIGIT: begin
                        if (!hex[4]) ferr_in = 1'b1;
                        if ({high_in, hex[3:0]} != xor_in) ferr_in = 1'b1;
                        phase_in = PH_DIGITS_DONE;
                     end
                     default: begin
                        phase_in = phase_in;
                     end
                  endcase
               end
               // Line feed closes the sentence
               if (rx_byte == CHAR_LF) begin
                  emit     = 1'b1;
                  len_wide = LenW'(count_in);
                  result.length = len_wide[LengthW-1:0];
                  if (ferr_in || phase_in != PH_DIGITS_DONE || pos < CountW'(3)) begin
                     result.status = STATUS_BAD;
                     result.kind   = KIND_NONE;
                  end else if (match_in[0]) begin
                     result.status = STATUS_OK;
                     result.kind   = KIND_RMC;
                  end else if (match_in[1]) begin
                     result.status = STATUS_OK;
                     result.kind   = KIND_GGA;
                  end else if (match_in[2]) begin
                     result.status = STATUS_OK;
                     result.kind   = KIND_VTG;
                  end else begin
                     result.status = STATUS_OTHER;
                     result.kind   = KIND_NONE;
                  end
                  in_sentence_in = 1'b0;
                  count_in       = '0;
                  xor_in         = '0;
                  phase_in       = PH_BEFORE_STAR;
                  high_in        = '0;
                  ferr_in        = 1'b0;
                  match_in       = 3'b111;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff <= 1'b0;
         count_ff       <= '0;
         xor_ff         <= '0;
         phase_ff       <= PH_BEFORE_STAR;
         high_ff        <= '0;
         ferr_ff        <= 1'b0;
         match_ff       <= 3'b111;
      end else begin
         in_sentence_ff <= in_sentence_in;
         count_ff       <= count_in;
         xor_ff         <= xor_in;
         phase_ff       <= phase_in;
         high_ff        <= high_in;
         ferr_ff        <= ferr_in;
         match_ff       <= match_in;
      end
   end

endmodule

// ===== hdl/nsfc_out_reg.sv =====
module nsfc_out_reg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  nsfc_pkg::result_type         result,
   output logic                         free,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [nsfc_pkg::StatusW-1:0] rsp_status,
   output logic [nsfc_pkg::KindW-1:0]   rsp_sentence_kind,
   output logic [nsfc_pkg::LengthW-1:0] rsp_line_length
);
   import nsfc_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // Room for a new word when empty or when the held word is taken now
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = data_ff.status;
   assign rsp_sentence_kind = data_ff.kind;
   assign rsp_line_length   = data_ff.length;

endmodule

// ===== hdl/nmea_sentence_framer_checker_unit.sv =====
// NMEA 0183 sentence framer and checksum checker. Takes one received serial byte
// per word and returns one word per sentence closed by a line feed: status (good
// known sentence, bad checksum or format, good but another type), kind (RMC, GGA,
// VTG) and length from the dollar through the line feed. A dollar always restarts
// the sentence; bytes outside a sentence and sentences longer than LINE_CAPACITY-1
// bytes give no word. A byte passes an input register and one short update of the
// sentence state into the result register, so one byte is taken every cycle; a
// result is loaded into the result register as its line feed leaves the input
// register, and the only stall is a held result.
module nmea_sentence_framer_checker_unit #(
   parameter int unsigned LINE_CAPACITY = nsfc_pkg::LineCapacityDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [nsfc_pkg::ByteW-1:0]   req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [nsfc_pkg::StatusW-1:0] rsp_status,
   output logic [nsfc_pkg::KindW-1:0]   rsp_sentence_kind,
   output logic [nsfc_pkg::LengthW-1:0] rsp_line_length
);
   import nsfc_pkg::*;

   logic             word_valid;
   logic [ByteW-1:0] word_byte;
   logic             out_free;
   logic             fire;
   logic             emit;
   result_type       result;

   // Advance a held byte whenever the result side has room
   assign fire = word_valid && out_free;

   nsfc_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .take        (fire),
      .word_valid  (word_valid),
      .word_byte   (word_byte)
   );

   nsfc_framer #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_framer (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .rx_byte (word_byte),
      .emit    (emit),
      .result  (result)
   );

   nsfc_out_reg u_out_reg (
      .clock             (clock),
      .reset             (reset),
      .load              (fire && emit),
      .result            (result),
      .free              (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_sentence_kind (rsp_sentence_kind),
      .rsp_line_length   (rsp_line_length)
   );

   // A good known sentence always names its kind
   a_ok_has_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_sentence_kind != KIND_NONE)
      else $error("good sentence without kind");

   // Any other status carries no kind
   a_other_no_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_sentence_kind == KIND_NONE)
      else $error("kind reported on a non-good sentence");

   // A full input register behind a stalled result blocks new bytes
   a_stall_blocks : assert property (@(posedge clock) disable iff (reset)
      word_valid && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("byte taken while the pipeline is stalled");

   // A byte moves on only when the result register is free, so its result is held valid
   a_fire_free : assert property (@(posedge clock) disable iff (reset)
      fire && emit |=> rsp_valid)
      else $error("result lost");

endmodule

// ===== verif/nmea_sentence_framer_checker_unit_tb.sv =====
module nmea_sentence_framer_checker_unit_tb;

   import nsfc_pkg::*;

   localparam int unsigned LINE_CAPACITY  = LineCapacityDefault;
   localparam int          RANDOM_BYTES   = 2000;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam logic [ByteW-1:0] CHAR_CR    = 8'h0D;
   localparam logic [ByteW-1:0] CHAR_COMMA = 8'h2C;

   // Sentence names, one row per kind in match-bit order: RMC, GGA, VTG
   localparam logic [ByteW-1:0] NAME_CHARS [3][3] = '{
      '{"R", "M", "C"}, '{"G", "G", "A"}, '{"V", "T", "G"}
   };

   typedef struct {
      logic [ByteW-1:0] rx_byte;
      bit               pinned;
      result_type       want;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [ByteW-1:0]    req_rx_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [StatusW-1:0]  rsp_status;
   logic [KindW-1:0]    rsp_sentence_kind;
   logic [LengthW-1:0]  rsp_line_length;

   // Typed-in expectation travelling alongside the byte on the request side
   bit                  req_pinned = 1'b0;
   result_type          req_pin_result = '0;

   result_type          sentence_q[$];
   stim_row_type        script_q[$];
   logic [ByteW-1:0]    line_q[$];
   int                  fail_count = 0;
   int                  quiet_cycles = 0;
   bit                  calm_tail = 1'b0;

   // Framer state mirrored by the predictor
   bit                  open_sentence;
   logic [7:0]          line_count;
   logic [ByteW-1:0]    running_sum;
   phase_type           digit_phase;
   logic [3:0]          high_nibble;
   bit                  bad_format;
   logic [2:0]          name_hits;

   nmea_sentence_framer_checker_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_sentence_kind (rsp_sentence_kind),
      .rsp_line_length   (rsp_line_length)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   // Bit 4 marks a hex digit, bits 3:0 give its value (zero when not a digit)
   function automatic logic [4:0] hex_value(input logic [ByteW-1:0] c);
      logic [ByteW-1:0] folded;
      folded = c | 8'h20;
      if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
      if (folded >= "a" && folded <= "f") return {1'b1, 4'(c[3:0] + 4'd9)};
      return 5'd0;
   endfunction

   function automatic logic [ByteW-1:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (lower ? 8'h57 : 8'h37) + 8'(n);
   endfunction

   function automatic void clear_frame();
      line_count  = '0;
      running_sum = '0;
      digit_phase = PH_BEFORE_STAR;
      high_nibble = '0;
      bad_format  = 1'b0;
      name_hits   = 3'b111;
   endfunction

   // Advance the framer by one byte; return 1 with the sentence word on a line feed
   function automatic bit frame_byte(input logic [ByteW-1:0] b, output result_type r);
      logic [7:0] pos;
      logic [4:0] dig;
      r = '0;
      if (b == CHAR_DOLLAR) begin
         clear_frame();
         open_sentence = 1'b1;
      end
      if (!open_sentence) return 1'b0;

      // drop an over-long sentence without a word
      if (int'(line_count) >= int'(LINE_CAPACITY) - 1) begin
         open_sentence = 1'b0;
         clear_frame();
         return 1'b0;
      end
      pos = line_count;
      line_count = line_count + 8'd1;

      if (pos >= 8'd3 && pos <= 8'd5) begin
         for (int k = 0; k < 3; k++) begin
            if (NAME_CHARS[k][pos - 8'd3] != b) name_hits[k] = 1'b0;
         end
      end

      if (pos > 8'd0) begin
         case (digit_phase)
            PH_BEFORE_STAR: begin
               if (b == CHAR_STAR) begin
                  digit_phase = PH_HIGH_DIGIT;
               end else begin
                  if (b == CHAR_NUL) bad_format = 1'b1;
                  running_sum ^= b;
               end
            end
            PH_HIGH_DIGIT: begin
               dig = hex_value(b);
               if (!dig[4]) bad_format = 1'b1;
               high_nibble = dig[3:0];
               digit_phase = PH_LOW_DIGIT;
            end
            PH_LOW_DIGIT: begin
               dig = hex_value(b);
               if (!dig[4]) bad_format = 1'b1;
               if ({high_nibble, dig[3:0]} != running_sum) bad_format = 1'b1;
               digit_phase = PH_DIGITS_DONE;
            end
            default: ;
         endcase
      end

      if (b != CHAR_LF) return 1'b0;

      // close the sentence: earliest matching name wins
      r.kind = KIND_NONE;
      if (bad_format || digit_phase != PH_DIGITS_DONE || pos < 8'd3) begin
         r.status = STATUS_BAD;
      end else if (name_hits[0]) begin
         r.status = STATUS_OK;
         r.kind   = KIND_RMC;
      end else if (name_hits[1]) begin
         r.status = STATUS_OK;
         r.kind   = KIND_GGA;
      end else if (name_hits[2]) begin
         r.status = STATUS_OK;
         r.kind   = KIND_VTG;
      end else begin
         r.status = STATUS_OTHER;
      end
      r.length = line_count[LengthW-1:0];
      open_sentence = 1'b0;
      clear_frame();
      return 1'b1;
   endfunction

   // Predict on accepted bytes, check returned words, watch for a hang
   always @(posedge clock) begin
      result_type got;
      result_type want;
      bit         fired;
      if (reset) begin
         open_sentence = 1'b0;
         clear_frame();
         quiet_cycles = 0;
      end else begin
         if (req_valid && req_ready) begin
            fired = frame_byte(req_rx_byte, got);
            if (req_pinned) sentence_q.push_back(req_pin_result);
            else if (fired) sentence_q.push_back(got);
         end
         if (rsp_valid && rsp_ready) begin
            if (sentence_q.size() == 0) begin
               report_mismatch($sformatf("unexpected word status %0d kind %0d length %0d",
                                         rsp_status, rsp_sentence_kind, rsp_line_length));
            end else begin
               want = sentence_q.pop_front();
               if (rsp_status != want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_status, want.status));
               if (rsp_sentence_kind != want.kind)
                  report_mismatch($sformatf("kind got %0d want %0d",
                                            rsp_sentence_kind, want.kind));
               if (rsp_line_length != want.length)
                  report_mismatch($sformatf("length got %0d want %0d",
                                            rsp_line_length, want.length));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no word moved for %0d cycles, %0d still expected",
                        quiet_cycles, sentence_q.size());
               $display("** nmea_sentence_framer_checker_unit: FAILED **");
               $finish;
            end
         end
      end
   end

   // Result side: stall in bursts, hold ready high in the closing stretch
   initial begin
      forever begin
         if (!calm_tail && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   // Offer one byte, with an occasional idle burst first, and hold until taken
   task automatic push_byte(input logic [ByteW-1:0] b, input bit pin, input result_type want);
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_rx_byte    <= b;
      req_pinned     <= pin;
      req_pin_result <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) script_q.push_back('{s[i], 1'b0, '0});
   endtask

   // Build one random line: well-formed sentences, flawed ones, short lines and noise
   task automatic compose_sentence();
      int               mode;
      int               flaw;
      int               fields;
      int               pick;
      bit               lower;
      logic [ByteW-1:0] c;
      logic [ByteW-1:0] sum;
      logic [4:0]       dig;
      line_q.delete();
      mode = $urandom_range(0, 15);
      if (mode == 0) begin
         repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      if (mode == 1) begin
         line_q.push_back(CHAR_DOLLAR);
         repeat ($urandom_range(0, 4)) line_q.push_back(8'($urandom_range(65, 90)));
         line_q.push_back(CHAR_LF);
         return;
      end
      // abandoned fragment, restarted by the next dollar
      if (mode == 2) begin
         line_q.push_back(CHAR_DOLLAR);
         repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(65, 90)));
      end

      line_q.push_back(CHAR_DOLLAR);
      sum  = '0;
      pick = $urandom_range(0, 3);
      for (int i = 0; i < 5; i++) begin
         c = (i >= 2 && pick < 3) ? NAME_CHARS[pick][i-2] : 8'($urandom_range(65, 90));
         line_q.push_back(c);
         sum ^= c;
      end

      fields = ($urandom_range(0, 11) == 0) ? $urandom_range(112, 124) : $urandom_range(0, 40);
      for (int i = 0; i < fields; i++) begin
         if ($urandom_range(0, 15) == 0) c = 8'($urandom_range(128, 255));
         else c = 8'($urandom_range(32, 126));
         if (c == CHAR_DOLLAR || c == CHAR_STAR) c = CHAR_COMMA;
         line_q.push_back(c);
         sum ^= c;
      end

      // flaw 0 drops star and digits, 1 plants a zero byte, 2 corrupts the sum, 3 a digit
      flaw = $urandom_range(0, 7);
      if (flaw == 1) line_q.push_back(CHAR_NUL);
      if (flaw != 0) begin
         line_q.push_back(CHAR_STAR);
         if (flaw == 2) sum ^= 8'($urandom_range(1, 255));
         lower = 1'($urandom_range(0, 1));
         line_q.push_back(hex_char(sum[7:4], lower));
         line_q.push_back(hex_char(sum[3:0], lower));
         if (flaw == 3) begin
            do begin
               c   = 8'($urandom_range(0, 255));
               dig = hex_value(c);
            end while (dig[4] || c == CHAR_DOLLAR);
            line_q[line_q.size() - 1 - $urandom_range(0, 1)] = c;
         end
         repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
               0:       line_q.push_back(CHAR_CR);
               1:       line_q.push_back(CHAR_STAR);
               2:       line_q.push_back(CHAR_NUL);
               default: line_q.push_back(8'($urandom_range(32, 126)));
            endcase
         end
      end
      line_q.push_back(CHAR_LF);
   endtask

   // Stimulus: directed table, then random lines, then drain and finish
   initial begin
      int sent;
      bit drained;
      sent    = 0;
      drained = 1'b0;

      // stray bytes before any dollar, at both extremes
      script_q.push_back('{8'hFF, 1'b0, '0});
      script_q.push_back('{CHAR_NUL, 1'b0, '0});
      // bare dollar and line feed: no star, too short
      add_text("$\n");
      script_q[$].pinned = 1'b1;
      script_q[$].want   = '{STATUS_BAD, KIND_NONE, 7'd2};
      // restart mid-sentence, lower-case digits, trailing carriage return
      add_text("$GP$GPRMC*4b\x0D\n");
      script_q[$].pinned = 1'b1;
      script_q[$].want   = '{STATUS_OK, KIND_RMC, 7'd11};
      add_text("$GPVTG*52\n");

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script_q[i]) push_byte(script_q[i].rx_byte, script_q[i].pinned, script_q[i].want);

      while (sent < RANDOM_BYTES) begin
         // hold off once until every outstanding word has returned
         if (!drained && sent >= RANDOM_BYTES / 2) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (sentence_q.size() != 0) @(posedge clock);
         end
         calm_tail = (sent >= RANDOM_BYTES * 4 / 5);
         compose_sentence();
         foreach (line_q[i]) push_byte(line_q[i], 1'b0, '0);
         sent += line_q.size();
      end
      req_valid <= 1'b0;

      while (sentence_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("** nmea_sentence_framer_checker_unit: PASSED **");
      end else begin
         $display("** nmea_sentence_framer_checker_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/nsfc_pkg.sv
hdl/nsfc_in_reg.sv
hdl/nsfc_framer.sv
hdl/nsfc_out_reg.sv
hdl/nmea_sentence_framer_checker_unit.sv
verif/nmea_sentence_framer_checker_unit_tb.sv
